// ===== src/aopt_pkg.sv =====
package aopt_pkg;

    // Request payloads
    typedef struct packed {
        logic signed [31:0] vert_dist;
        logic signed [31:0] horiz_dist;
        logic signed [31:0] heading;
    } t_in;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
    } t_out;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 22;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_OFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_OFF = 2'd1;
    localparam logic signed [CFG_DATA_W-1:0] VERT_OFF_RESET  = 22'sd0;
    localparam logic signed [CFG_DATA_W-1:0] HORIZ_OFF_RESET = 22'sd131072;

    // Step index width; covers the longest iteration (the divider)
    localparam int IDX_W = 6;

    // CORDIC vector and angle widths
    localparam int XW = 34;
    localparam int ZW = 35;
    localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic [33:0] Q30_TWO_PI_U         = 34'd6746518852;
    localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

    // Chord magnitude limit, 2^37-1
    localparam int CW = 38;
    localparam logic [36:0] CHORD_LIM = 37'h1F_FFFF_FFFF;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_NOCHORD,
        OP_ANG,
        OP_MOD,
        OP_FOLD,
        OP_CORDIC,
        OP_TRIG,
        OP_DIV_LD,
        OP_DIV_STEP,
        OP_RAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_CHORD,
        OP_PSET,
        OP_PACC,
        OP_UPDATE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic dth_zero;
    } t_stat;

    // Q30 arctangent of 2^-i
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 35'sh03243F6A8;
            5'd1:  v = 35'sh01DAC6705;
            5'd2:  v = 35'sh00FADBAFC;
            5'd3:  v = 35'sh007F56EA6;
            5'd4:  v = 35'sh003FEAB76;
            5'd5:  v = 35'sh001FFD55B;
            5'd6:  v = 35'sh000FFFAAA;
            5'd7:  v = 35'sh0007FFF55;
            5'd8:  v = 35'sh0003FFFEA;
            5'd9:  v = 35'sh0001FFFFD;
            5'd10: v = 35'sh0000FFFFF;
            5'd11: v = 35'sh00007FFFF;
            5'd12: v = 35'sh00003FFFF;
            5'd13: v = 35'sh00001FFFF;
            5'd14: v = 35'sh00000FFFF;
            5'd15: v = 35'sh000007FFF;
            5'd16: v = 35'sh000003FFF;
            5'd17: v = 35'sh000001FFF;
            5'd18: v = 35'sh000000FFF;
            5'd19: v = 35'sh0000007FF;
            5'd20: v = 35'sh0000003FF;
            5'd21: v = 35'sh0000001FF;
            5'd22: v = 35'sh0000000FF;
            5'd23: v = 35'sh00000007F;
            5'd24: v = 35'sh00000003F;
            5'd25: v = 35'sh00000001F;
            5'd26: v = 35'sh00000000F;
            5'd27: v = 35'sh000000008;
            5'd28: v = 35'sh000000004;
            5'd29: v = 35'sh000000002;
            default: v = 35'sh000000001;
        endcase
        return v;
    endfunction

endpackage

// ===== src/aopt_ctrl.sv =====
module aopt_ctrl #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  aopt_pkg::t_stat  i_stat,
    output aopt_pkg::t_cmd   o_cmd
);

    localparam int MOD_STEPS = 30 - FRAC_BITS;
    localparam int DIV_STEPS = 33 + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ANG, S_MOD, S_FOLD, S_CORD, S_TRIG, S_DIVLD,
        S_DIV, S_RAD, S_MLO, S_MHI, S_CHORD, S_PSET, S_PACC, S_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [aopt_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic                       r_mid, n_mid;
    logic                       r_wheel, n_wheel;
    logic [1:0]                 r_prod, n_prod;
    logic                       r_out_valid, n_out_valid;
    logic                       update;

    // Sequence the datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mid   = r_mid;
        n_wheel = r_wheel;
        n_prod  = r_prod;
        update  = 1'b0;
        o_cmd.op  = aopt_pkg::OP_NONE;
        o_cmd.idx = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = aopt_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.dth_zero) begin
                    o_cmd.op = aopt_pkg::OP_NOCHORD;
                    n_mid    = 1'b1;
                end else begin
                    n_mid    = 1'b0;
                end
                n_state = S_ANG;
            end
            S_ANG: begin
                o_cmd.op  = aopt_pkg::OP_ANG;
                o_cmd.idx = aopt_pkg::IDX_W'(r_mid);
                n_cnt     = '0;
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.op  = aopt_pkg::OP_MOD;
                o_cmd.idx = r_cnt;
                if (r_cnt == aopt_pkg::IDX_W'(MOD_STEPS - 1)) begin
                    n_state = S_FOLD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FOLD: begin
                o_cmd.op = aopt_pkg::OP_FOLD;
                n_cnt    = '0;
                n_state  = S_CORD;
            end
            S_CORD: begin
                o_cmd.op  = aopt_pkg::OP_CORDIC;
                o_cmd.idx = r_cnt;
                if (r_cnt == aopt_pkg::IDX_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_TRIG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TRIG: begin
                o_cmd.op  = aopt_pkg::OP_TRIG;
                o_cmd.idx = aopt_pkg::IDX_W'(r_mid);
                if (r_mid) begin
                    n_prod  = 2'd0;
                    n_state = S_PSET;
                end else begin
                    n_wheel = 1'b0;
                    n_state = S_DIVLD;
                end
            end
            S_DIVLD: begin
                o_cmd.op  = aopt_pkg::OP_DIV_LD;
                o_cmd.idx = aopt_pkg::IDX_W'(r_wheel);
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = aopt_pkg::OP_DIV_STEP;
                if (r_cnt == aopt_pkg::IDX_W'(DIV_STEPS - 1)) begin
                    n_state = S_RAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RAD: begin
                o_cmd.op  = aopt_pkg::OP_RAD;
                o_cmd.idx = aopt_pkg::IDX_W'(r_wheel);
                n_state   = S_MLO;
            end
            S_MLO: begin
                o_cmd.op = aopt_pkg::OP_MUL_LO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                o_cmd.op = aopt_pkg::OP_MUL_HI;
                n_state  = r_mid ? S_PACC : S_CHORD;
            end
            S_CHORD: begin
                o_cmd.op  = aopt_pkg::OP_CHORD;
                o_cmd.idx = aopt_pkg::IDX_W'(r_wheel);
                if (!r_wheel) begin
                    n_wheel = 1'b1;
                    n_state = S_DIVLD;
                end else begin
                    n_mid   = 1'b1;
                    n_state = S_ANG;
                end
            end
            S_PSET: begin
                o_cmd.op  = aopt_pkg::OP_PSET;
                o_cmd.idx = aopt_pkg::IDX_W'(r_prod);
                n_state   = S_MLO;
            end
            S_PACC: begin
                o_cmd.op  = aopt_pkg::OP_PACC;
                o_cmd.idx = aopt_pkg::IDX_W'(r_prod);
                if (r_prod == 2'd3) begin
                    n_state = S_OUT;
                end else begin
                    n_prod  = r_prod + 1'b1;
                    n_state = S_PSET;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = aopt_pkg::OP_UPDATE;
                    update   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || update;
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mid       <= 1'b0;
            r_wheel     <= 1'b0;
            r_prod      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mid       <= n_mid;
            r_wheel     <= n_wheel;
            r_prod      <= n_prod;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/aopt_datapath.sv =====
module aopt_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aopt_pkg::t_cmd                      i_cmd,
    output aopt_pkg::t_stat                     o_stat,
    input  aopt_pkg::t_in                       i_in_data,
    input  logic                                i_cfg_we,
    input  logic [aopt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [aopt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output aopt_pkg::t_out                      o_out_data
);

    localparam int F    = FRAC_BITS;
    localparam int AW   = 63 - F;   // signed angle width, Q30
    localparam int MODK = 29 - F;   // top shift of the modulo sweep
    localparam int DQ   = 33 + F;   // dividend / quotient width
    localparam int RW   = 35 + F;   // radius width
    localparam int TW   = F + 4;    // sin / cos width
    localparam int XW   = aopt_pkg::XW;
    localparam int ZW   = aopt_pkg::ZW;
    localparam int CW   = aopt_pkg::CW;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -65'sd2147483648) r = 32'sh8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

    aopt_pkg::t_op    op;
    logic [aopt_pkg::IDX_W-1:0] idx;

    aopt_pkg::t_in              r_in;
    logic signed [31:0]         r_prior_v, r_prior_h, r_prior_th, r_pos_x, r_pos_y;
    logic signed [21:0]         r_off_v, r_off_h;
    logic signed [32:0]         r_dv, r_dh, r_dth;
    logic [AW-1:0]              r_ang_mag;
    logic                       r_ang_neg;
    logic signed [XW-1:0]       r_x, r_y;
    logic signed [ZW-1:0]       r_z;
    logic                       r_flip;
    logic signed [TW-1:0]       r_s2, r_sn, r_cs;
    logic [32:0]                r_rem, r_den;
    logic [DQ-1:0]              r_quo;
    logic                       r_qneg;
    logic [63:0]                r_ma;
    logic [31:0]                r_mb;
    logic                       r_mneg;
    logic [95:0]                r_acc;
    logic signed [CW-1:0]       r_vc, r_hc;
    logic signed [63:0]         r_sx, r_sy;

    logic signed [32:0]         dv_n, dh_n, dth_n;
    logic signed [AW-1:0]       a_dth, a_sel;
    logic [AW-1:0]              a_mag, mod_sub;
    logic [aopt_pkg::IDX_W-1:0] mod_k;
    logic signed [ZW-1:0]       f_r, f_z0, f_z1, f_z2;
    logic                       f_flip;
    logic signed [XW-1:0]       c_xs, c_ys;
    logic signed [ZW-1:0]       c_at;
    logic signed [XW-1:0]       t_x, t_y;
    logic signed [TW-1:0]       sn_n, cs_n;
    logic signed [32:0]         d_sel;
    logic [32:0]                d_mag, den_mag;
    logic [33:0]                rem_sh;
    logic                       rem_ge;
    logic [32:0]                rem_n;
    logic signed [RW-1:0]       q_s, rad;
    logic [RW-1:0]              rad_mag;
    logic [TW-1:0]              s2_mag;
    logic [31:0]                m_a;
    logic [63:0]                m_p;
    logic [95:0]                ch_sh;
    logic [36:0]                ch_mag;
    logic signed [CW-1:0]       ch_v;
    logic signed [CW-1:0]       ps_c;
    logic signed [TW-1:0]       ps_t;
    logic [CW-1:0]              ps_cm;
    logic [TW-1:0]              ps_tm;
    logic signed [63:0]         p_s;
    logic signed [31:0]         ux, uy;

    assign op  = i_cmd.op;
    assign idx = i_cmd.idx;

    // Form per-operation values
    always_comb begin
        // sample differences
        dv_n  = 33'(i_in_data.vert_dist)  - 33'(r_prior_v);
        dh_n  = 33'(i_in_data.horiz_dist) - 33'(r_prior_h);
        dth_n = 33'(i_in_data.heading)    - 33'(r_prior_th);

        // angle in Q30: half the heading change, optionally plus prior heading
        a_dth = AW'(r_dth) <<< (29 - F);
        a_sel = idx[0] ? ((AW'(r_prior_th) <<< (30 - F)) + a_dth) : a_dth;
        a_mag = a_sel[AW-1] ? AW'(-a_sel) : AW'(a_sel);

        // one conditional subtract of 2*pi shifted by k
        mod_k   = aopt_pkg::IDX_W'(MODK) - idx;
        mod_sub = AW'(aopt_pkg::Q30_TWO_PI_U) << mod_k;

        // restore sign, wrap into [-pi, pi], fold into [-pi/2, pi/2]
        f_r  = $signed(ZW'(r_ang_mag));
        f_z0 = r_ang_neg ? -f_r : f_r;
        f_z1 = f_z0;
        if (f_z0 > aopt_pkg::Q30_PI)       f_z1 = f_z0 - aopt_pkg::Q30_TWO_PI;
        else if (f_z0 < -aopt_pkg::Q30_PI) f_z1 = f_z0 + aopt_pkg::Q30_TWO_PI;
        f_z2   = f_z1;
        f_flip = 1'b0;
        if (f_z1 > aopt_pkg::Q30_HALF_PI) begin
            f_z2   = f_z1 - aopt_pkg::Q30_PI;
            f_flip = 1'b1;
        end else if (f_z1 < -aopt_pkg::Q30_HALF_PI) begin
            f_z2   = f_z1 + aopt_pkg::Q30_PI;
            f_flip = 1'b1;
        end

        // CORDIC micro-rotation
        c_xs = r_x >>> idx;
        c_ys = r_y >>> idx;
        c_at = aopt_pkg::atan_q30(idx[4:0]);

        // sin and cos down to Q.FRAC_BITS
        t_x  = r_flip ? -r_x : r_x;
        t_y  = r_flip ? -r_y : r_y;
        sn_n = TW'(t_y >>> (30 - F));
        cs_n = TW'(t_x >>> (30 - F));

        // divider operands and one restoring step
        d_sel   = idx[0] ? r_dh : r_dv;
        d_mag   = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
        den_mag = r_dth[32] ? 33'(-r_dth) : 33'(r_dth);
        rem_sh  = {r_rem, r_quo[DQ-1]};
        rem_ge  = (rem_sh >= {1'b0, r_den});
        rem_n   = rem_ge ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];

        // radius = quotient + offset
        q_s     = r_qneg ? -$signed(RW'(r_quo)) : $signed(RW'(r_quo));
        rad     = q_s + RW'(idx[0] ? r_off_h : r_off_v);
        rad_mag = rad[RW-1] ? RW'(-rad) : RW'(rad);
        s2_mag  = r_s2[TW-1] ? TW'(-r_s2) : TW'(r_s2);

        // shared 32x32 multiplier over the low or high half
        m_a = (op == aopt_pkg::OP_MUL_HI) ? r_ma[63:32] : r_ma[31:0];
        m_p = 64'(m_a) * 64'(r_mb);

        // chord = product / 2^F, saturated
        ch_sh  = r_acc >> F;
        ch_mag = (ch_sh > 96'(aopt_pkg::CHORD_LIM)) ? aopt_pkg::CHORD_LIM : ch_sh[36:0];
        ch_v   = r_mneg ? -$signed(CW'(ch_mag)) : $signed(CW'(ch_mag));

        // final rotation operand pairs: cs*hc, sn*vc, sn*hc, cs*vc
        ps_c  = (idx[1:0] == 2'd0 || idx[1:0] == 2'd2) ? r_hc : r_vc;
        ps_t  = (idx[1:0] == 2'd0 || idx[1:0] == 2'd3) ? r_cs : r_sn;
        ps_cm = ps_c[CW-1] ? CW'(-ps_c) : CW'(ps_c);
        ps_tm = ps_t[TW-1] ? TW'(-ps_t) : TW'(ps_t);
        p_s   = r_mneg ? -$signed(r_acc[63:0]) : $signed(r_acc[63:0]);

        // position update
        ux = sat32(65'(r_pos_x) + 65'(r_sx >>> F));
        uy = sat32(65'(r_pos_y) + 65'(r_sy >>> F));
    end

    // Hold pose, prior sample and offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_v  <= '0;
            r_prior_h  <= '0;
            r_prior_th <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_off_v    <= aopt_pkg::VERT_OFF_RESET;
            r_off_h    <= aopt_pkg::HORIZ_OFF_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aopt_pkg::REG_VERT_OFF:  r_off_v <= $signed(i_cfg_data);
                    aopt_pkg::REG_HORIZ_OFF: r_off_h <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (op == aopt_pkg::OP_UPDATE) begin
                r_pos_x    <= ux;
                r_pos_y    <= uy;
                r_prior_v  <= r_in.vert_dist;
                r_prior_h  <= r_in.horiz_dist;
                r_prior_th <= r_in.heading;
            end
        end
    end

    // Advance the working registers
    always_ff @(posedge i_clk) begin
        unique case (op)
            aopt_pkg::OP_LOAD: begin
                r_in  <= i_in_data;
                r_dv  <= dv_n;
                r_dh  <= dh_n;
                r_dth <= dth_n;
            end
            aopt_pkg::OP_NOCHORD: begin
                r_vc <= CW'(r_dv);
                r_hc <= CW'(r_dh);
            end
            aopt_pkg::OP_ANG: begin
                r_ang_mag <= a_mag;
                r_ang_neg <= a_sel[AW-1];
            end
            aopt_pkg::OP_MOD: begin
                if (r_ang_mag >= mod_sub) r_ang_mag <= r_ang_mag - mod_sub;
            end
            aopt_pkg::OP_FOLD: begin
                r_x    <= aopt_pkg::Q30_GAIN;
                r_y    <= '0;
                r_z    <= f_z2;
                r_flip <= f_flip;
            end
            aopt_pkg::OP_CORDIC: begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - c_ys;
                    r_y <= r_y + c_xs;
                    r_z <= r_z - c_at;
                end else begin
                    r_x <= r_x + c_ys;
                    r_y <= r_y - c_xs;
                    r_z <= r_z + c_at;
                end
            end
            aopt_pkg::OP_TRIG: begin
                if (idx[0]) begin
                    r_sn <= sn_n;
                    r_cs <= cs_n;
                end else begin
                    r_s2 <= sn_n <<< 1;
                end
            end
            aopt_pkg::OP_DIV_LD: begin
                r_rem  <= '0;
                r_quo  <= DQ'(d_mag) << F;
                r_den  <= den_mag;
                r_qneg <= d_sel[32] ^ r_dth[32];
            end
            aopt_pkg::OP_DIV_STEP: begin
                r_rem <= rem_n;
                r_quo <= {r_quo[DQ-2:0], rem_ge};
            end
            aopt_pkg::OP_RAD: begin
                r_ma   <= 64'(rad_mag);
                r_mb   <= 32'(s2_mag);
                r_mneg <= rad[RW-1] ^ r_s2[TW-1];
            end
            aopt_pkg::OP_MUL_LO: r_acc <= {32'b0, m_p};
            aopt_pkg::OP_MUL_HI: r_acc <= r_acc + {m_p, 32'b0};
            aopt_pkg::OP_CHORD: begin
                if (idx[0]) r_hc <= ch_v;
                else        r_vc <= ch_v;
            end
            aopt_pkg::OP_PSET: begin
                r_ma   <= 64'(ps_cm);
                r_mb   <= 32'(ps_tm);
                r_mneg <= ps_c[CW-1] ^ ps_t[TW-1];
            end
            aopt_pkg::OP_PACC: begin
                case (idx[1:0])
                    2'd0:    r_sx <= p_s;
                    2'd1:    r_sx <= r_sx - p_s;
                    2'd2:    r_sy <= p_s;
                    default: r_sy <= r_sy + p_s;
                endcase
            end
            default: ;
        endcase
    end

    assign o_stat.dth_zero       = (r_dth == '0);
    assign o_out_data.x_position = r_pos_x;
    assign o_out_data.y_position = r_pos_y;

endmodule

// ===== src/arc_odometry_pose_tracker.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data  (vert_dist, horiz_dist, heading)
// out       output     o_out_valid / i_out_stall o_out_data (x_position, y_position)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One request at a time. With no heading change a request skips the divider and runs
// the CORDIC loop once; otherwise its length is set by the shared restoring divider
// (33 + FRAC_BITS steps per wheel) and the CORDIC loop.
// Reset is synchronous, active low; pose, prior sample and offsets return to reset values.
// A finished pose waits in the output register; a new request is taken meanwhile, and
// its update waits until the earlier pose is taken.
module arc_odometry_pose_tracker #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  aopt_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output aopt_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [aopt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aopt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    aopt_pkg::t_cmd  cmd;
    aopt_pkg::t_stat stat;

    aopt_ctrl #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    aopt_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

    // An accepted request blocks the input until its pose is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a request");

    // The pose changes only together with a presented result
    a_pose_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_out_data) |-> o_out_valid)
        else $error("pose changed without a result");

    // A result appears only at the end of a request's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised while idle");

endmodule
